// File: src/mwu_pkg.sv
package mwu_pkg;

  // Store geometry and fixed field widths.
  localparam int MAX_SAMPLES = 512;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int VAL_W       = 32;
  localparam int ENTRY_W     = VAL_W + 1;
  localparam int TU_W        = 18;
  localparam int Z_W         = 16;
  localparam int CV_W        = 16;

  // Widths of the z-score arithmetic.
  localparam int NM_W   = 17;
  localparam int SUM_W  = 10;
  localparam int DEN_W  = 26;
  localparam int SQ_W   = 33;
  localparam int NUM_W  = 50;
  localparam int Q_W    = 34;
  localparam int ROOT_W = 17;
  localparam int DCNT_W = 6;

  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_SAMPLES);
  localparam logic [DCNT_W-1:0] DIV_LAST_STEP = DCNT_W'(NUM_W - 1);
  localparam logic [Q_W-1:0]    Q_CLAMP = Q_W'(1) << 33;

  // Configuration register addressing.
  localparam int PADDR_W = 3;
  localparam logic REG_CRITICAL = 1'b0;
  localparam logic [CV_W-1:0] CV_RESET = CV_W'(502);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_STORE, ST_MUL1, ST_MUL2, ST_MUL3,
    ST_MUL4, ST_DIV, ST_SQRT, ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic store;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_none;
    logic scan_end;
    logic last;
    logic err;
    logic div_last;
    logic sqrt_last;
    logic out_busy;
  } stat_t;

endpackage

// File: src/mwu_if.sv
interface mwu_sample_if;
  import mwu_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sample_value;
  logic             sample_group;
  logic             last_sample;
  modport source (output valid, sample_value, sample_group, last_sample, input ready);
  modport sink (input valid, sample_value, sample_group, last_sample, output ready);
endinterface

interface mwu_result_if;
  import mwu_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [TU_W-1:0]        twice_u;
  logic signed [Z_W-1:0]  z_score;
  logic                   violation;
  logic                   error_flag;
  modport source (output valid, twice_u, z_score, violation, error_flag, input ready);
  modport sink (input valid, twice_u, z_score, violation, error_flag, output ready);
endinterface

// File: src/mwu_ram.sv
module mwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/mwu_ctrl.sv
module mwu_ctrl
  import mwu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t status,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.scan_none ? ST_STORE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_STORE;
      ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = status.last ? ST_MUL1 : ST_IDLE;
      end
      ST_MUL1: begin
        if (status.err) begin
          state_next = ST_FIN;
        end else begin
          cmd.mul1   = 1'b1;
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = ST_MUL4;
      end
      ST_MUL4: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.sqrt_init = 1'b1;
          state_next    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/mwu_dp.sv
module mwu_dp
  import mwu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 status,
  input  logic [VAL_W-1:0]      in_value,
  input  logic                  in_group,
  input  logic                  in_last,
  input  logic [CV_W-1:0]       critical_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TU_W-1:0]       out_twice_u,
  output logic signed [Z_W-1:0] out_z_score,
  output logic                  out_violation,
  output logic                  out_error_flag
);

  logic [VAL_W-1:0]  cur_val;
  logic              cur_grp;
  logic              cur_last;
  logic [CNT_W-1:0]  n1, n2, total;
  logic [TU_W-1:0]   acc;
  logic              ovf;
  logic              full;
  logic [ADDR_W-1:0] scan_idx;
  logic              rd_vld;
  logic [ENTRY_W-1:0] rd_data;
  logic [1:0]        pair_add;
  logic [NM_W-1:0]   nm;
  logic [SUM_W-1:0]  nsum;
  logic [DEN_W-1:0]  den;
  logic              neg;
  logic [NM_W-1:0]   mag;
  logic [SQ_W-1:0]   sq;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DCNT_W-1:0] div_cnt;
  logic [DEN_W:0]    shifted;
  logic [Q_W-1:0]    q_clamped;
  logic [ROOT_W-1:0] root, sq_bit, trial;
  logic [2*ROOT_W-1:0] trial_sq;
  logic signed [Z_W-1:0] z_val;
  logic signed [TU_W-1:0] z_ext, cv_neg;
  logic              err;

  assign total = n1 + n2;
  assign full  = (total >= CNT_MAX);
  assign err   = ovf || (n1 == '0) || (n2 == '0);

  assign status.scan_none = (total == '0) || full;
  assign status.scan_end  = ({1'b0, scan_idx} == (total - CNT_W'(1)));
  assign status.last      = cur_last;
  assign status.err       = err;
  assign status.div_last  = (div_cnt == DIV_LAST_STEP);
  assign status.sqrt_last = sq_bit[0];
  assign status.out_busy  = out_valid && !out_ready;

  // Sample store: group bit over value.
  mwu_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SAMPLES)) u_store (
    .clk  (clk),
    .we   (cmd.store && !full),
    .waddr(total[ADDR_W-1:0]),
    .wdata({cur_grp, cur_val}),
    .raddr(scan_idx),
    .rdata(rd_data)
  );

  // Pair score of the current sample against one stored sample.
  always_comb begin
    pair_add = 2'd0;
    if (rd_vld && (rd_data[VAL_W] != cur_grp)) begin
      if (rd_data[VAL_W-1:0] == cur_val) begin
        pair_add = 2'd1;
      end else if (cur_grp ? (rd_data[VAL_W-1:0] < cur_val)
                           : (rd_data[VAL_W-1:0] > cur_val)) begin
        pair_add = 2'd2;
      end
    end
  end

  // Load state: counts, accumulator and overflow mark.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      n1     <= '0;
      n2     <= '0;
      acc    <= '0;
      ovf    <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
      acc    <= acc + TU_W'(pair_add);
      if (cmd.store) begin
        if (full) begin
          ovf <= 1'b1;
        end else if (cur_grp) begin
          n2 <= n2 + CNT_W'(1);
        end else begin
          n1 <= n1 + CNT_W'(1);
        end
      end
    end
  end

  // Current transaction and scan address.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_val  <= in_value;
      cur_grp  <= in_group;
      cur_last <= in_last;
      scan_idx <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + ADDR_W'(1);
    end
  end

  // Products for the variance term and the squared deviation.
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      nm   <= NM_W'(n1 * n2);
      nsum <= SUM_W'(n1 + n2 + CNT_W'(1));
    end
    if (cmd.mul2) begin
      den <= DEN_W'(nm * nsum);
      neg <= (acc < TU_W'(nm));
      mag <= (acc >= TU_W'(nm)) ? NM_W'(acc - TU_W'(nm)) : NM_W'(TU_W'(nm) - acc);
    end
    if (cmd.mul3) begin
      sq <= SQ_W'(mag * mag);
    end
  end

  // Restoring divider: 196608 * mag^2 / den, one quotient bit a cycle.
  assign shifted = {rem, quo[NUM_W-1]};
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= '0;
      quo     <= {(Q_W'(sq) + Q_W'({sq, 1'b0})), 16'd0};
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DCNT_W'(1);
      if (shifted >= {1'b0, den}) begin
        rem <= DEN_W'(shifted - {1'b0, den});
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign q_clamped = (quo > NUM_W'(Q_CLAMP)) ? Q_CLAMP : quo[Q_W-1:0];

  // Square root, one result bit a cycle from the top.
  assign trial    = root | sq_bit;
  assign trial_sq = trial * trial;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      root   <= '0;
      sq_bit <= ROOT_W'(1) << (ROOT_W - 1);
    end else if (cmd.sqrt_step) begin
      sq_bit <= sq_bit >> 1;
      if (trial_sq <= q_clamped) begin
        root <= trial;
      end
    end
  end

  // Signed, saturated z and the violation decision.
  always_comb begin
    if (neg) begin
      z_val = (root >= ROOT_W'(32768)) ? 16'sh8000 : -$signed(root[Z_W-1:0]);
    end else begin
      z_val = (root >= ROOT_W'(32767)) ? 16'sh7fff : $signed(root[Z_W-1:0]);
    end
  end
  assign z_ext  = TU_W'(z_val);
  assign cv_neg = -$signed({2'b00, critical_value});

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_error_flag <= err;
      out_twice_u    <= err ? '0 : acc;
      out_z_score    <= err ? '0 : z_val;
      out_violation  <= err ? 1'b0 : (z_ext < cv_neg);
    end
  end

`ifndef SYNTH
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (n1 == '0 && n2 == '0 && acc == '0 && !ovf))
    else $error("load state not cleared after result");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, n1} + {1'b0, n2}) <= (CNT_W + 1)'(MAX_SAMPLES))
    else $error("sample count beyond store depth");
  a_store_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.store && !full && !cmd.clear) |=> (total == $past(total) + CNT_W'(1)))
    else $error("stored sample not counted");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("pending result overwritten");
`endif

endmodule

// File: src/mann_whitney_u_test.sv
// Two-sample rank test over a stream of tagged samples. samples channel: one
// transaction carries sample_value, sample_group (0 or 1) and last_sample.
// Unless the store is full, each sample is compared with every stored sample,
// one store read a cycle, then written into a 512-entry store. A sample with
// last_sample clear gets a scan of the samples stored before it, a drain step
// for the registered read and a store step before the next is accepted; an
// empty or full store skips the scan and drain. A sample with last_sample set
// then takes three multiply steps, a divider setup step, a restoring divider,
// a square root and the output step; an error load skips from the first
// multiply step to the output step. results channel: one transaction per
// load with twice_u, z_score (signed Q8.8, saturated), violation and
// error_flag. With error_flag set (an empty group or a sample offered to a
// full store) the other fields are zero. The result sits in an output
// register; a stalled receiver holds the block in its final step until the
// register is taken, then the load state clears. Reset clears counts and
// accumulator and sets critical_value to 502; the store contents need no
// clearing. critical_value is written over the APB port at byte address 0;
// the user must write it only while idle; the block does not enforce this.
module mann_whitney_u_test
  import mwu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  mwu_sample_if.sink         samples,
  mwu_result_if.source       results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CV_W-1:0] critical_value;
  cmd_t            cmd;
  stat_t           status;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      critical_value <= CV_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CRITICAL)) begin
      critical_value <= pwdata[CV_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_CRITICAL) ? {16'd0, critical_value} : 32'd0;

  mwu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(samples.valid),
    .in_ready(samples.ready),
    .status  (status),
    .cmd     (cmd)
  );

  mwu_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_value      (samples.sample_value),
    .in_group      (samples.sample_group),
    .in_last       (samples.last_sample),
    .critical_value(critical_value),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_twice_u   (results.twice_u),
    .out_z_score   (results.z_score),
    .out_violation (results.violation),
    .out_error_flag(results.error_flag)
  );

endmodule

// File: tb/mann_whitney_u_test_tb.sv
module mann_whitney_u_test_tb;
  import mwu_pkg::*;

  // Tracks the state of one load and the queue of expected results.
  class mwu_scoreboard;
    logic [VAL_W-1:0] vals[$];
    logic             grps[$];
    int unsigned      n1, n2;
    longint unsigned  pairs;
    bit               ovf;
    logic [CV_W-1:0]  crit;
    logic [TU_W-1:0]  exp_tu[$];
    logic [Z_W-1:0]   exp_z[$];
    logic             exp_viol[$];
    logic             exp_err[$];
    int               errors;

    function new();
      crit = CV_RESET;
      clear_load();
      errors = 0;
    endfunction

    function void clear_load();
      vals.delete();
      grps.delete();
      n1 = 0;
      n2 = 0;
      pairs = 0;
      ovf = 0;
    endfunction

    function longint unsigned root_floor(longint unsigned q);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 17;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= q) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    // Q8.8 normal approximation from 2U and the group sizes.
    function int z_of(longint unsigned tu, longint unsigned n, longint unsigned m);
      longint unsigned nm, mag, den, a, q1, r1, q, k;
      bit neg;
      nm = n * m;
      neg = tu < nm;
      mag = neg ? nm - tu : tu - nm;
      den = nm * (n + m + 1);
      a = mag * mag;
      q1 = a / den;
      r1 = a % den;
      if (q1 > 65536) q = 64'd1 << 33;
      else q = 196608 * q1 + (196608 * r1) / den;
      if (q > (64'd1 << 33)) q = 64'd1 << 33;
      k = root_floor(q);
      if (neg) return (k >= 32768) ? -32768 : -int'(k);
      return (k >= 32767) ? 32767 : int'(k);
    endfunction

    // Notes an accepted sample transaction.
    function void note_sample(logic [VAL_W-1:0] v, logic g, logic lst);
      bit err;
      int z;
      if (vals.size() >= MAX_SAMPLES) begin
        ovf = 1;
      end else begin
        foreach (vals[i]) begin
          if (grps[i] != g) begin
            if (vals[i] == v) pairs += 1;
            else if (g == 1'b0 ? vals[i] > v : vals[i] < v) pairs += 2;
          end
        end
        vals = {vals, v};
        grps = {grps, g};
        if (g) n2++;
        else n1++;
      end
      if (!lst) return;
      err = ovf || n1 == 0 || n2 == 0;
      z = err ? 0 : z_of(pairs, n1, n2);
      exp_tu = {exp_tu, (err ? TU_W'(0) : TU_W'(pairs))};
      exp_z = {exp_z, Z_W'(z)};
      exp_viol = {exp_viol, logic'(!err && (z < -int'(crit)))};
      exp_err = {exp_err, logic'(err)};
      clear_load();
    endfunction

    // Checks one accepted result transaction.
    function void check_result(logic [TU_W-1:0] tu, logic [Z_W-1:0] z, logic viol,
                               logic err);
      if (exp_tu.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
        return;
      end
      if (tu !== exp_tu[0]) begin
        $error("twice_u expected %0d actual %0d", exp_tu[0], tu);
        errors++;
      end
      if (z !== exp_z[0]) begin
        $error("z_score expected %0d actual %0d", $signed(exp_z[0]), $signed(z));
        errors++;
      end
      if (viol !== exp_viol[0]) begin
        $error("violation expected %0b actual %0b", exp_viol[0], viol);
        errors++;
      end
      if (err !== exp_err[0]) begin
        $error("error_flag expected %0b actual %0b", exp_err[0], err);
        errors++;
      end
      void'(exp_tu.pop_front());
      void'(exp_z.pop_front());
      void'(exp_viol.pop_front());
      void'(exp_err.pop_front());
    endfunction
  endclass

  localparam int IDLE_LIMIT = 200000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  bit long_stall = 0;
  bit stall_done = 0;
  int idle_cycles = 0;

  mwu_sample_if samples_if();
  mwu_result_if results_if();
  mwu_scoreboard rank_book = new();

  mann_whitney_u_test dut (
    .clk(clk), .rst(rst), .samples(samples_if.sink), .results(results_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Monitor: score inputs and check outputs at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (samples_if.valid && samples_if.ready)
        rank_book.note_sample(samples_if.sample_value, samples_if.sample_group,
                              samples_if.last_sample);
      if (results_if.valid && results_if.ready)
        rank_book.check_result(results_if.twice_u, results_if.z_score,
                               results_if.violation, results_if.error_flag);
      if ((samples_if.valid && samples_if.ready) ||
          (results_if.valid && results_if.ready) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall pattern plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 0;
    end else if (long_stall && !stall_done) begin
      results_if.ready <= 0;
    end else begin
      case ($urandom_range(0, 3))
        0: results_if.ready <= 0;
        default: results_if.ready <= 1;
      endcase
    end
  end

  initial begin
    wait (long_stall);
    repeat (6000) @(posedge clk);
    stall_done = 1;
  end

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_critical(logic [CV_W-1:0] cv);
    apb_write(PADDR_W'(0), 32'(cv));
    rank_book.crit = cv;
  endtask

  // Offers one sample, holding it until accepted; an optional gap follows.
  task automatic send_sample(logic [VAL_W-1:0] v, logic g, logic lst, int gap);
    samples_if.valid <= 1;
    samples_if.sample_value <= v;
    samples_if.sample_group <= g;
    samples_if.last_sample <= lst;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    if (gap > 0) begin
      samples_if.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    samples_if.valid <= 0;
    @(posedge clk);
    while (rank_book.exp_tu.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(int spread);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return VAL_W'($urandom);
      default: return VAL_W'($urandom_range(0, spread));
    endcase
  endfunction

  // One load of random samples, in bursts with gaps.
  task automatic random_load(int len, int spread, int bias);
    int burst;
    burst = 0;
    for (int i = 0; i < len; i++) begin
      int gap;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      end else begin
        gap = 0;
      end
      burst--;
      send_sample(pick_value(spread), $urandom_range(0, 99) < bias, i == len - 1,
                  burst == 0 ? gap : 0);
    end
  endtask

  initial begin
    int len;
    samples_if.valid = 0;
    samples_if.sample_value = '0;
    samples_if.sample_group = 0;
    samples_if.last_sample = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, ties, empty groups, separated groups.
    send_sample('0, 0, 0, 0);
    send_sample('1, 1, 0, 0);
    send_sample(32'h5555_AAAA, 0, 0, 1);
    send_sample(32'hAAAA_5555, 1, 1, 0);
    send_sample(32'd7, 0, 0, 0);
    send_sample(32'd7, 1, 0, 0);
    send_sample(32'd7, 1, 1, 2);
    send_sample(32'd3, 0, 1, 0);
    send_sample(32'd3, 1, 0, 0);
    send_sample(32'd4, 1, 1, 0);
    for (int i = 0; i < 6; i++) send_sample(VAL_W'(100 + i), 1, 0, 0);
    for (int i = 0; i < 6; i++) send_sample(VAL_W'(i), 0, i == 5, 0);
    send_sample('1, 1, 1, 0);
    drain_results();

    // Store overflow: one more sample than the store holds.
    for (int i = 0; i <= MAX_SAMPLES; i++)
      send_sample(VAL_W'($urandom_range(0, 50)), i[0], i == MAX_SAMPLES, 0);
    drain_results();

    // Random loads across critical value settings; long hold-off in one phase.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_critical('0);
        1: set_critical('1);
        2: set_critical(CV_W'(502));
        default: set_critical(CV_W'($urandom_range(0, 2000)));
      endcase
      if (ph == 2) long_stall = 1;
      for (int k = 0; k < 8; k++) begin
        len = (k == 0 && ph == 3) ? 100 : $urandom_range(1, 16);
        random_load(len, $urandom_range(0, 1) ? 8 : 1000, $urandom_range(10, 90));
      end
      drain_results();
    end

    if (rank_book.errors == 0 && rank_book.exp_tu.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: mann_whitney_u_test.f
src/mwu_pkg.sv
src/mwu_if.sv
src/mwu_ram.sv
src/mwu_ctrl.sv
src/mwu_dp.sv
src/mann_whitney_u_test.sv
tb/mann_whitney_u_test_tb.sv
